FILE: rtl/core/swsplit_pkg.sv
`timescale 1ns / 1ps

package swsplit_pkg;

   // Character codes that steer the splitter.
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   // Default depth of the queue between front and back.
   localparam int SW_QUEUE_DEPTH = 4;

   typedef logic [7:0] char_type;

   // Class of a character as the front sees it.
   typedef enum logic [2:0] {
      CLS_OTHER  = 3'd0,
      CLS_SPACE  = 3'd1,
      CLS_SQUOTE = 3'd2,
      CLS_DQUOTE = 3'd3,
      CLS_BSLASH = 3'd4
   } class_type;

   // One classified character waiting for the back.
   typedef struct packed {
      char_type  ch;
      class_type cls;
      logic      last;
   } entry_type;

   // One finished result.
   typedef struct packed {
      char_type ch;
      logic     keep;
      logic     word_done;
      logic     line_done;
      logic     line_ok;
   } result_type;

   // Quoting state of the back, one-hot.
   typedef enum logic [4:0] {
      MODE_PLAIN  = 5'b00001,
      MODE_SINGLE = 5'b00010,
      MODE_DOUBLE = 5'b00100,
      MODE_ESC    = 5'b01000,
      MODE_DESC   = 5'b10000
   } mode_type;

endpackage

FILE: rtl/core/shell_word_splitter.sv
`timescale 1ns / 1ps

// Channel   Ports                                  Transfer when
// input     req_char_in, req_line_end, req_push    req_push && !req_full
// result    rsp_char_out .. rsp_line_ok, rsp_pop   rsp_pop && !rsp_empty
//
// One character per cycle sustained, with both sides free to stall.
// A result passes through the queue behind the classifier and then through
// the state machine's output register.
// Reset clears the quoting state and empties the queue and the output register.
// When the output stalls, the queue fills and req_full rises.

module shell_word_splitter #(
   parameter int QUEUE_DEPTH = swsplit_pkg::SW_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  swsplit_pkg::char_type req_char_in,
   input  logic                  req_line_end,
   input  logic                  req_push,
   output logic                  req_full,
   output swsplit_pkg::char_type rsp_char_out,
   output logic                  rsp_keep,
   output logic                  rsp_word_done,
   output logic                  rsp_line_done,
   output logic                  rsp_line_ok,
   output logic                  rsp_empty,
   input  logic                  rsp_pop
);
   import swsplit_pkg::*;

   entry_type  front_entry;
   entry_type  queue_entry;
   logic       queue_empty;
   logic       queue_pop;
   result_type result;
   logic       result_valid;

   // Front: classify each incoming character.
   swsplit_front u_front (
      .char_in  (req_char_in),
      .line_end (req_line_end),
      .entry    (front_entry)
   );

   // Queue between the classifier and the state machine.
   swsplit_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (front_entry),
      .full    (req_full),
      .pop     (queue_pop),
      .rd_data (queue_entry),
      .empty   (queue_empty)
   );

   // Back: quoting state machine and output register.
   swsplit_back u_back (
      .clock        (clock),
      .reset        (reset),
      .entry        (queue_entry),
      .entry_valid  (!queue_empty),
      .entry_take   (queue_pop),
      .result       (result),
      .result_valid (result_valid),
      .result_take  (rsp_pop)
   );

   assign rsp_empty     = !result_valid;
   assign rsp_char_out  = result.ch;
   assign rsp_keep      = result.keep;
   assign rsp_word_done = result.word_done;
   assign rsp_line_done = result.line_done;
   assign rsp_line_ok   = result.line_ok;

endmodule

FILE: rtl/core/swsplit_front.sv
`timescale 1ns / 1ps

module swsplit_front (
   input  swsplit_pkg::char_type  char_in,
   input  logic                   line_end,
   output swsplit_pkg::entry_type entry
);
   import swsplit_pkg::*;

   class_type cls;

   // Sort the incoming character into the classes that the back acts on.
   always_comb begin
      priority if (char_in == CH_SPACE) begin
         cls = CLS_SPACE;
      end else if (char_in == CH_SQUOTE) begin
         cls = CLS_SQUOTE;
      end else if (char_in == CH_DQUOTE) begin
         cls = CLS_DQUOTE;
      end else if (char_in == CH_BSLASH) begin
         cls = CLS_BSLASH;
      end else begin
         cls = CLS_OTHER;
      end
   end

   assign entry.ch   = char_in;
   assign entry.cls  = cls;
   assign entry.last = line_end;

endmodule

FILE: rtl/core/swsplit_queue.sv
`timescale 1ns / 1ps

module swsplit_queue #(
   parameter int DEPTH = swsplit_pkg::SW_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  swsplit_pkg::entry_type wr_data,
   output logic                   full,
   input  logic                   pop,
   output swsplit_pkg::entry_type rd_data,
   output logic                   empty
);
   import swsplit_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // Pointers wrap at the depth; the count tracks the fill level.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/core/swsplit_back.sv
`timescale 1ns / 1ps

module swsplit_back (
   input  logic                    clock,
   input  logic                    reset,
   input  swsplit_pkg::entry_type  entry,
   input  logic                    entry_valid,
   output logic                    entry_take,
   output swsplit_pkg::result_type result,
   output logic                    result_valid,
   input  logic                    result_take
);
   import swsplit_pkg::*;

   mode_type   mode_ff, mode_in;
   logic       word_ff, word_in;
   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   mode_type   step_mode;
   logic       step_word;
   logic       keep;
   logic       done;
   logic       ok;

   // Take the next entry whenever the output register is free or drains now.
   assign entry_take   = entry_valid && (!out_valid_ff || result_take);
   assign result       = out_ff;
   assign result_valid = out_valid_ff;

   // Quoting state machine for one character.
   always_comb begin
      step_mode = mode_ff;
      step_word = word_ff;
      keep      = 1'b0;
      done      = 1'b0;
      unique case (mode_ff)
         MODE_SINGLE: begin
            if (entry.cls == CLS_SQUOTE) begin
               step_mode = MODE_PLAIN;
            end else begin
               keep = 1'b1;
            end
         end
         MODE_DOUBLE: begin
            if (entry.cls == CLS_DQUOTE) begin
               step_mode = MODE_PLAIN;
            end else if (entry.cls == CLS_BSLASH) begin
               step_mode = MODE_DESC;
            end else begin
               keep = 1'b1;
            end
         end
         MODE_ESC: begin
            keep      = 1'b1;
            step_mode = MODE_PLAIN;
         end
         MODE_DESC: begin
            keep      = 1'b1;
            step_mode = MODE_DOUBLE;
         end
         default: begin
            step_mode = MODE_PLAIN;
            if (entry.cls == CLS_SPACE) begin
               done      = word_ff;
               step_word = 1'b0;
            end else if (entry.cls == CLS_SQUOTE) begin
               step_mode = MODE_SINGLE;
            end else if (entry.cls == CLS_DQUOTE) begin
               step_mode = MODE_DOUBLE;
            end else if (entry.cls == CLS_BSLASH) begin
               step_mode = MODE_ESC;
            end else begin
               keep = 1'b1;
            end
         end
      endcase
      if (keep) begin
         step_word = 1'b1;
      end
      // The last character closes the line and restores the idle state.
      ok = entry.last && (step_mode == MODE_PLAIN);
      if (ok && step_word) begin
         done = 1'b1;
      end
      if (entry.last) begin
         step_mode = MODE_PLAIN;
         step_word = 1'b0;
      end
   end

   // State and output register updates.
   always_comb begin
      mode_in      = mode_ff;
      word_in      = word_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !result_take;
      if (entry_take) begin
         mode_in          = step_mode;
         word_in          = step_word;
         out_in.ch        = keep ? entry.ch : '0;
         out_in.keep      = keep;
         out_in.word_done = done;
         out_in.line_done = entry.last;
         out_in.line_ok   = ok;
         out_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PLAIN;
         word_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         word_ff      <= word_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule
